@@ hw/rtl/iprf_pkg.sv @@
// ----------------------------------------------------------------------------
// iprf_pkg
// shared constants, codes and types of the indexed region prefetch filter
// ----------------------------------------------------------------------------
package iprf_pkg;

    // filter and address geometry
    localparam int FILTER_DEPTH = 256;
    localparam int LINE_BYTES   = 64;
    localparam int ADDR_W       = 48;
    localparam int IDX_W        = 32;
    localparam int ELEM_W       = 16;
    localparam int STATUS_W     = 2;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = ADDR_W;

    localparam int LINE_SHIFT   = $clog2(LINE_BYTES);
    localparam int TAG_W        = ADDR_W - LINE_SHIFT;
    localparam int PTR_W        = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
    localparam int CNT_W        = $clog2(FILTER_DEPTH + 1);
    localparam int PROD_W       = IDX_W + ELEM_W;
    localparam int SUM_W        = ((ADDR_W > PROD_W) ? ADDR_W : PROD_W) + 1;

    // queue between front and back
    localparam int WQ_DEPTH     = 2;
    localparam int WQ_PTR_W     = (WQ_DEPTH > 1) ? $clog2(WQ_DEPTH) : 1;
    localparam int WQ_CNT_W     = $clog2(WQ_DEPTH + 1);

    localparam logic [ELEM_W-1:0] ELEM_BYTES_RESET = ELEM_W'(1);

    typedef enum logic [STATUS_W-1:0] {
        ST_ISSUED         = 2'd0,
        ST_NOT_CONFIGURED = 2'd1,
        ST_OUTSIDE        = 2'd2,
        ST_DUPLICATE      = 2'd3
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_REGION_ENABLE = 2'd0,
        CFG_REGION_BASE   = 2'd1,
        CFG_REGION_LIMIT  = 2'd2,
        CFG_ELEMENT_BYTES = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic              enable;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] limit;
        logic [ELEM_W-1:0] elem_bytes;
    } region_cfg_t;

    // classified hint; ST_ISSUED here means "candidate for the filter"
    typedef struct packed {
        status_t          status;
        logic [TAG_W-1:0] tag;
    } work_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_INSERT,
        BK_RESULT
    } back_state_t;

endpackage

@@ hw/rtl/indexed_region_prefetch_filter_unit.sv @@
// ----------------------------------------------------------------------------
// indexed_region_prefetch_filter_unit
// turns element index hints into filtered, line-aligned prefetch addresses
// ----------------------------------------------------------------------------
// Each hint beat carries an element index. The unit forms base + index *
// element_bytes at full width, rejects it if the region is disabled (status
// not configured) or the address falls outside [base, limit), and otherwise
// looks the cache line up in a fifo filter of the most recently issued
// lines: a line already present is reported as a duplicate, a new one is
// issued and written at the fifo insert pointer, replacing the oldest
// entry once the filter is full. Exactly one result beat leaves per hint,
// in order. Hints enter through a two-stage front (one multiplier stage,
// then add, compare and classify) into a two-entry work queue, so the
// front keeps taking hints while the back is busy, until the queue fills.
// The back handles one hint at a time: a rejected hint goes straight to
// its result; a filter candidate scans the tag memory one entry per cycle
// through its single read port, over at most the filled entries, ending
// early on a duplicate. The filter starts empty after reset through a fill
// count, with no clearing pass. Configuration is taken at any time (cfg_ready
// is always high) but must only be written while no hint is in flight.
// ----------------------------------------------------------------------------
module indexed_region_prefetch_filter_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    // hint side
    input  logic                              push,
    output logic                              full,
    input  logic [iprf_pkg::IDX_W-1:0]        target_index,
    // result side
    output logic                              empty,
    input  logic                              pop,
    output logic [iprf_pkg::STATUS_W-1:0]     status,
    output logic [iprf_pkg::ADDR_W-1:0]       prefetch_line,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [iprf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [iprf_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import iprf_pkg::*;

    region_cfg_t cfg_reg;
    region_cfg_t cfg_next;
    logic        cfg_write;

    work_t       fq_item;
    logic        fq_push;
    logic        fq_full;
    work_t       bq_item;
    logic        bq_pop;
    logic        bq_empty;

    // configuration registers, always ready
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_REGION_ENABLE: cfg_next.enable     = cfg_data[0];
                CFG_REGION_BASE:   cfg_next.base       = cfg_data[ADDR_W-1:0];
                CFG_REGION_LIMIT:  cfg_next.limit      = cfg_data[ADDR_W-1:0];
                CFG_ELEMENT_BYTES: cfg_next.elem_bytes = cfg_data[ELEM_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable     <= 1'b0;
            cfg_reg.base       <= '0;
            cfg_reg.limit      <= '0;
            cfg_reg.elem_bytes <= ELEM_BYTES_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: multiply, region check and line tag
    iprf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .target_index (target_index),
        .cfg          (cfg_reg),
        .q_push       (fq_push),
        .q_item       (fq_item),
        .q_full       (fq_full)
    );

    // decouples the front from the filter scan
    iprf_work_q u_work_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (fq_push),
        .item_in  (fq_item),
        .full     (fq_full),
        .pop      (bq_pop),
        .item_out (bq_item),
        .empty    (bq_empty)
    );

    // back: filter lookup, insert and result beat
    iprf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (bq_empty),
        .q_item        (bq_item),
        .q_pop         (bq_pop),
        .empty         (empty),
        .pop           (pop),
        .status        (status),
        .prefetch_line (prefetch_line)
    );

endmodule

@@ hw/rtl/iprf_ram.sv @@
// ----------------------------------------------------------------------------
// iprf_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module iprf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic                                         re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/iprf_work_q.sv @@
// ----------------------------------------------------------------------------
// iprf_work_q
// short register queue of classified hints between front and back
// ----------------------------------------------------------------------------
module iprf_work_q (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  iprf_pkg::work_t item_in,
    output logic            full,
    input  logic            pop,
    output iprf_pkg::work_t item_out,
    output logic            empty
);
    import iprf_pkg::*;

    work_t                entries_reg [WQ_DEPTH];
    logic [WQ_PTR_W-1:0]  wr_ptr_reg;
    logic [WQ_PTR_W-1:0]  wr_ptr_next;
    logic [WQ_PTR_W-1:0]  rd_ptr_reg;
    logic [WQ_PTR_W-1:0]  rd_ptr_next;
    logic [WQ_CNT_W-1:0]  count_reg;
    logic [WQ_CNT_W-1:0]  count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full     = (count_reg == WQ_CNT_W'(WQ_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign item_out = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == WQ_PTR_W'(WQ_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == WQ_PTR_W'(WQ_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

@@ hw/rtl/iprf_front.sv @@
// ----------------------------------------------------------------------------
// iprf_front
// hint intake: index times element size, region check, line tag
// ----------------------------------------------------------------------------
module iprf_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [iprf_pkg::IDX_W-1:0]  target_index,
    input  iprf_pkg::region_cfg_t       cfg,
    output logic                        q_push,
    output iprf_pkg::work_t             q_item,
    input  logic                        q_full
);
    import iprf_pkg::*;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [PROD_W-1:0] s1_product_reg;
    logic              advance;
    logic              accept;
    logic [SUM_W-1:0]  addr_sum;
    logic              in_region;

    assign advance = !s1_valid_reg || !q_full;
    assign full    = !advance;
    assign accept  = push && advance;
    assign q_push  = s1_valid_reg && !q_full;

    assign s1_valid_next = advance ? accept : s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // one 32x16 product per beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_product_reg <= PROD_W'(target_index) * PROD_W'(cfg.elem_bytes);
        end
    end

    // full-width sum, never wraps; below base is impossible
    assign addr_sum  = SUM_W'(cfg.base) + SUM_W'(s1_product_reg);
    assign in_region = (addr_sum < SUM_W'(cfg.limit));

    always_comb
    begin
        q_item.tag = addr_sum[ADDR_W-1:LINE_SHIFT];
        if (!cfg.enable)
        begin
            q_item.status = ST_NOT_CONFIGURED;
        end
        else if (!in_region)
        begin
            q_item.status = ST_OUTSIDE;
        end
        else
        begin
            q_item.status = ST_ISSUED;
        end
    end

endmodule

@@ hw/rtl/iprf_back.sv @@
// ----------------------------------------------------------------------------
// iprf_back
// filter scan, fifo insert and result register
// ----------------------------------------------------------------------------
module iprf_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_empty,
    input  iprf_pkg::work_t                q_item,
    output logic                           q_pop,
    output logic                           empty,
    input  logic                           pop,
    output logic [iprf_pkg::STATUS_W-1:0]  status,
    output logic [iprf_pkg::ADDR_W-1:0]    prefetch_line
);
    import iprf_pkg::*;

    back_state_t        state_reg;
    back_state_t        state_next;
    work_t              cur_reg;
    logic [CNT_W-1:0]   scan_idx_reg;
    logic [CNT_W-1:0]   scan_idx_next;
    logic               rd_pend_reg;
    logic [PTR_W-1:0]   ins_ptr_reg;
    logic [PTR_W-1:0]   ins_ptr_next;
    logic [CNT_W-1:0]   fill_reg;
    logic [CNT_W-1:0]   fill_next;
    logic               res_valid_reg;
    logic               res_valid_next;
    status_t            res_status_reg;
    logic [ADDR_W-1:0]  res_line_reg;

    logic [TAG_W-1:0]   rdata;
    logic               hit;
    logic               scan_more;
    logic               slot_free;
    logic               rd_issue;
    logic               ram_we;
    logic               res_load;
    logic               set_dup;

    assign hit       = rd_pend_reg && (rdata == cur_reg.tag);
    assign scan_more = (scan_idx_reg != fill_reg);
    assign slot_free = !res_valid_reg || pop;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    if (q_item.status != ST_ISSUED)
                    begin
                        state_next = BK_RESULT;
                    end
                    else if (fill_reg == '0)
                    begin
                        state_next = BK_INSERT;
                    end
                    else
                    begin
                        state_next = BK_SCAN;
                    end
                end
            end
            BK_SCAN:
            begin
                if (hit)
                begin
                    state_next = BK_RESULT;
                end
                else if (!scan_more)
                begin
                    state_next = BK_INSERT;
                end
            end
            BK_INSERT:
            begin
                state_next = BK_RESULT;
            end
            BK_RESULT:
            begin
                if (slot_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        q_pop    = 1'b0;
        rd_issue = 1'b0;
        ram_we   = 1'b0;
        res_load = 1'b0;
        set_dup  = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                q_pop = !q_empty;
            end
            BK_SCAN:
            begin
                rd_issue = scan_more && !hit;
                set_dup  = hit;
            end
            BK_INSERT:
            begin
                ram_we = 1'b1;
            end
            BK_RESULT:
            begin
                res_load = slot_free;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        scan_idx_next  = scan_idx_reg;
        ins_ptr_next   = ins_ptr_reg;
        fill_next      = fill_reg;
        res_valid_next = res_valid_reg;
        if (q_pop)
        begin
            scan_idx_next = '0;
        end
        else if (rd_issue)
        begin
            scan_idx_next = scan_idx_reg + 1'b1;
        end
        if (ram_we)
        begin
            ins_ptr_next = (ins_ptr_reg == PTR_W'(FILTER_DEPTH - 1)) ? '0
                                                                    : ins_ptr_reg + 1'b1;
            if (fill_reg != CNT_W'(FILTER_DEPTH))
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (pop)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            scan_idx_reg  <= '0;
            rd_pend_reg   <= 1'b0;
            ins_ptr_reg   <= '0;
            fill_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_idx_reg  <= scan_idx_next;
            rd_pend_reg   <= rd_issue;
            ins_ptr_reg   <= ins_ptr_next;
            fill_reg      <= fill_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_item;
        end
        else if (set_dup)
        begin
            cur_reg.status <= ST_DUPLICATE;
        end
        if (res_load)
        begin
            res_status_reg <= cur_reg.status;
            res_line_reg   <= (cur_reg.status == ST_ISSUED)
                              ? {cur_reg.tag, {LINE_SHIFT{1'b0}}} : '0;
        end
    end

    iprf_ram #(
        .WIDTH (TAG_W),
        .DEPTH (FILTER_DEPTH)
    ) u_tag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ins_ptr_reg),
        .wdata (cur_reg.tag),
        .re    (rd_issue),
        .raddr (scan_idx_reg[PTR_W-1:0]),
        .rdata (rdata)
    );

    assign empty         = !res_valid_reg;
    assign status        = res_status_reg;
    assign prefetch_line = res_line_reg;

endmodule
